/* src/lghm_pkg.sv */
// shared types, constants and helpers for the loop gap histogram monitor
package lghm_pkg;

    localparam int BUCKET_COUNT_DEF = 8;
    localparam int BUCKET_IDX_MAX_W = 4;

    localparam int LOOP_TIME_W = 63;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam logic [31:0] ALL_ONES32    = 32'hFFFF_FFFF;
    localparam logic [31:0] PERIOD_RESET  = 32'd5000;
    localparam logic        REG_PERIOD    = 1'b0;

    localparam logic [31:0] BOUND_0 = 32'd1000;
    localparam logic [31:0] BOUND_1 = 32'd2000;
    localparam logic [31:0] BOUND_2 = 32'd5000;
    localparam logic [31:0] BOUND_3 = 32'd10000;
    localparam logic [31:0] BOUND_4 = 32'd20000;
    localparam logic [31:0] BOUND_5 = 32'd50000;
    localparam logic [31:0] BOUND_6 = 32'd100000;

    typedef enum logic [1:0] {
        CMD_LOOP  = 2'd0,
        CMD_AUDIO = 2'd1,
        CMD_WEB   = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic gap_en;
        logic clear;
    } hist_ctrl_t;

    typedef struct packed {
        logic [31:0] p95_bound;
        logic [31:0] gap_max;
    } hist_stat_t;

    function automatic logic [31:0] bound_of(input logic [BUCKET_IDX_MAX_W-1:0] idx);
        logic [31:0] bound;
        case (idx)
            4'd0:    bound = BOUND_0;
            4'd1:    bound = BOUND_1;
            4'd2:    bound = BOUND_2;
            4'd3:    bound = BOUND_3;
            4'd4:    bound = BOUND_4;
            4'd5:    bound = BOUND_5;
            4'd6:    bound = BOUND_6;
            default: bound = ALL_ONES32;
        endcase
        return bound;
    endfunction

endpackage

/* src/lghm_cfg.sv */
// apb register block holding the report period
module lghm_cfg
    import lghm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [31:0]       period
);

    logic [31:0] period_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (wr_en)
        begin
            period_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_PERIOD) ? period_reg : '0;
    assign period = period_reg;

endmodule

/* src/lghm_hist.sv */
// loop gap histogram: gap measurement, bucket counters, running prefix sums, p95 pick
module lghm_hist
    import lghm_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hist_ctrl_t             ctrl,
    input  logic [LOOP_TIME_W-1:0] loop_time,
    output hist_stat_t             stat
);

    localparam int IDX_W = $clog2(BUCKET_COUNT);
    localparam int CUM_W = 32 + IDX_W;
    localparam int CMP_W = CUM_W + 5;

    logic [LOOP_TIME_W-1:0] prev_time_reg;
    logic [31:0]            cnt_reg [BUCKET_COUNT];
    // cum_reg[b] holds the sum of counters 0..b, last entry is the total
    logic [CUM_W-1:0]       cum_reg [BUCKET_COUNT];
    logic [31:0]            gap_max_reg;

    logic [LOOP_TIME_W:0]   diff;
    logic [31:0]            gap;
    logic                   has_prev;
    logic [IDX_W-1:0]       sel;
    logic                   cnt_inc;
    logic [CMP_W-1:0]       total_x19;
    logic [BUCKET_COUNT-2:0] hit;
    logic [31:0]            p95;

    assign has_prev = (prev_time_reg != '0);
    assign diff     = {1'b0, loop_time} - {1'b0, prev_time_reg};

    always_comb
    begin
        // backwards time keeps the low word of the wrapped difference
        if (diff[LOOP_TIME_W])
            gap = diff[31:0];
        else if (|diff[LOOP_TIME_W-1:32])
            gap = ALL_ONES32;
        else
            gap = diff[31:0];
    end

    always_comb
    begin
        sel = IDX_W'(BUCKET_COUNT - 1);
        for (int b = BUCKET_COUNT - 2; b >= 0; b--)
        begin
            if (!(gap > bound_of(BUCKET_IDX_MAX_W'(b))))
                sel = IDX_W'(b);
        end
    end

    assign cnt_inc = ctrl.gap_en & has_prev & (cnt_reg[sel] != ALL_ONES32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            gap_max_reg   <= '0;
            for (int b = 0; b < BUCKET_COUNT; b++)
            begin
                cnt_reg[b] <= '0;
                cum_reg[b] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            gap_max_reg <= '0;
            for (int b = 0; b < BUCKET_COUNT; b++)
            begin
                cnt_reg[b] <= '0;
                cum_reg[b] <= '0;
            end
        end
        else if (ctrl.gap_en)
        begin
            prev_time_reg <= loop_time;
            if (has_prev && (gap > gap_max_reg))
                gap_max_reg <= gap;
            if (cnt_inc)
            begin
                for (int b = 0; b < BUCKET_COUNT; b++)
                begin
                    if (IDX_W'(b) == sel)
                        cnt_reg[b] <= cnt_reg[b] + 32'd1;
                    if (IDX_W'(b) >= sel)
                        cum_reg[b] <= cum_reg[b] + CUM_W'(1);
                end
            end
        end
    end

    // percentile test cum*20 >= total*19, all at full width
    assign total_x19 = CMP_W'({cum_reg[BUCKET_COUNT-1], 4'b0})
                     + CMP_W'({cum_reg[BUCKET_COUNT-1], 1'b0})
                     + CMP_W'(cum_reg[BUCKET_COUNT-1]);

    always_comb
    begin
        for (int b = 0; b < BUCKET_COUNT - 1; b++)
        begin
            hit[b] = ((CMP_W'({cum_reg[b], 4'b0}) + CMP_W'({cum_reg[b], 2'b0})) >= total_x19);
        end
    end

    always_comb
    begin
        p95 = ALL_ONES32;
        for (int b = BUCKET_COUNT - 2; b >= 0; b--)
        begin
            if (hit[b])
                p95 = bound_of(BUCKET_IDX_MAX_W'(b));
        end
    end

    assign stat.p95_bound = p95;
    assign stat.gap_max   = gap_max_reg;

endmodule

/* src/loop_gap_histogram_monitor.sv */
// loop gap histogram monitor top level: input register, event handling, report register
// Takes one item per cycle while in_stall is low. An accepted item is held in the input
// register and handled there; a report then passes the report register to the output. Loop
// gaps, bucket counters with running prefix sums and the three maxima are all updated when
// an item is handled, and the 95th-percentile bucket is picked by parallel compares over
// the prefix sums. A reporting tick waits in the input register only while the previous
// report is still held by a stalled output; every other item passes regardless. No clearing
// pass follows reset. The report period is written through the APB port at byte address 0.
module loop_gap_histogram_monitor
    import lghm_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic [LOOP_TIME_W-1:0] loop_time_us,
    input  logic [31:0]            elapsed_us,
    input  logic [31:0]            now_ms,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            report_time_ms,
    output logic [31:0]            p95_gap_bound_us,
    output logic [31:0]            gap_peak_us,
    output logic [31:0]            audio_max_us,
    output logic [31:0]            web_max_us
);

    logic [31:0]            period;

    logic                   in_valid_reg;
    cmd_t                   cmd_reg;
    logic [LOOP_TIME_W-1:0] loop_time_reg;
    logic [31:0]            elapsed_reg;
    logic [31:0]            now_reg;

    logic [31:0]            audio_max_reg;
    logic [31:0]            web_max_reg;
    logic [31:0]            last_report_reg;

    logic                   out_valid_reg;
    logic [31:0]            rpt_time_reg;
    logic [31:0]            rpt_p95_reg;
    logic [31:0]            rpt_gap_reg;
    logic [31:0]            rpt_audio_reg;
    logic [31:0]            rpt_web_reg;

    logic                   accept;
    logic                   report;
    logic                   go;
    hist_ctrl_t             hctrl;
    hist_stat_t             hstat;

    lghm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .period  (period)
    );

    assign report   = (cmd_reg == CMD_TICK) && ((now_reg - last_report_reg) >= period);
    // only a reporting item needs the result register free
    assign go       = in_valid_reg & ~(report & out_valid_reg & out_stall);
    assign in_stall = in_valid_reg & ~go;
    assign accept   = in_valid & ~in_stall;

    assign hctrl.gap_en = go & (cmd_reg == CMD_LOOP);
    assign hctrl.clear  = go & report;

    lghm_hist #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (hctrl),
        .loop_time (loop_time_reg),
        .stat      (hstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd_t'(command);
            loop_time_reg <= loop_time_us;
            elapsed_reg   <= elapsed_us;
            now_reg       <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_max_reg   <= '0;
            web_max_reg     <= '0;
            last_report_reg <= '0;
        end
        else if (go)
        begin
            case (cmd_reg)
                CMD_AUDIO:
                begin
                    if (elapsed_reg > audio_max_reg)
                        audio_max_reg <= elapsed_reg;
                end
                CMD_WEB:
                begin
                    if (elapsed_reg > web_max_reg)
                        web_max_reg <= elapsed_reg;
                end
                CMD_TICK:
                begin
                    if (report)
                    begin
                        audio_max_reg   <= '0;
                        web_max_reg     <= '0;
                        last_report_reg <= now_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && report)
        begin
            rpt_time_reg  <= now_reg;
            rpt_p95_reg   <= hstat.p95_bound;
            rpt_gap_reg   <= hstat.gap_max;
            rpt_audio_reg <= audio_max_reg;
            rpt_web_reg   <= web_max_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign report_time_ms   = rpt_time_reg;
    assign p95_gap_bound_us = rpt_p95_reg;
    assign gap_peak_us      = rpt_gap_reg;
    assign audio_max_us     = rpt_audio_reg;
    assign web_max_us       = rpt_web_reg;

endmodule

/* src/lghm_checker.sv */
// port-level checks for the loop gap histogram monitor, bound to the top level
module lghm_checker
    import lghm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] report_time_ms,
    input logic [31:0] p95_gap_bound_us,
    input logic [31:0] gap_peak_us,
    input logic [31:0] audio_max_us,
    input logic [31:0] web_max_us
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(report_time_ms) && $stable(p95_gap_bound_us)
            && $stable(gap_peak_us) && $stable(audio_max_us) && $stable(web_max_us))
        else $error("stalled result changed");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_p95_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> p95_gap_bound_us == BOUND_0 || p95_gap_bound_us == BOUND_1
            || p95_gap_bound_us == BOUND_2 || p95_gap_bound_us == BOUND_3
            || p95_gap_bound_us == BOUND_4 || p95_gap_bound_us == BOUND_5
            || p95_gap_bound_us == BOUND_6 || p95_gap_bound_us == ALL_ONES32)
        else $error("percentile bound is not a bucket bound");

endmodule

bind loop_gap_histogram_monitor lghm_checker u_lghm_checker (.*);
